### design/cholesky_spd_inverse_assert.svh
// Assertion macros used by the Cholesky inverse design file.
`ifndef CHOLESKY_SPD_INVERSE_ASSERT_SVH
`define CHOLESKY_SPD_INVERSE_ASSERT_SVH
`ifndef SYNTH
`define CSPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`define CSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CSPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/cspd_pkg.sv
// Types, constants and fixed-point helpers for the Cholesky inverse block.
package cspd_pkg;

  localparam int VW           = 32;
  localparam int DEF_MAX_SIZE = 8;
  localparam int SIZE_W       = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef struct packed {
    logic signed [VW-1:0] element_value;
    logic                 last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [VW-1:0] inverse_value;
    logic                 last_result;
    logic                 pivot_not_positive;
  } out_item_t;

  function automatic logic signed [VW-1:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    vmax = 64'sh0000_0000_7FFF_FFFF;
    vmin = -64'sh0000_0000_8000_0000;
    if (v > vmax) return vmax[VW-1:0];
    if (v < vmin) return vmin[VW-1:0];
    return v[VW-1:0];
  endfunction

  // Round to nearest (half up) and drop 16 fraction bits.
  function automatic logic signed [VW-1:0] qmul(input logic signed [63:0] prod);
    logic signed [63:0] t;
    t = (prod + 64'sd32768) >>> 16;
    return sat64(t);
  endfunction

endpackage

### design/cspd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cspd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/cholesky_spd_inverse.sv
// Cholesky-based inverse of a symmetric positive-definite Q16.16 matrix.
// Loading takes one cycle per element; start is taken whenever busy is low.
// The last element starts a sequenced run that uses the shared divider
// (a division per off-diagonal factor entry and per inverse entry).
// Results leave one at a time on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears size to 8, load count and error flag.
module cholesky_spd_inverse #(
  parameter int MAX_SIZE = cspd_pkg::DEF_MAX_SIZE
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  cspd_pkg::in_item_t           in_data,
  output logic                         out_valid,
  output cspd_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cspd_pkg::SIZE_W-1:0]  cfg_data
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CW    = $clog2(MAX_SIZE + 1);
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int VW    = cspd_pkg::VW;
  localparam int AccW  = VW + 4;

  typedef enum logic [24:0] {
    ST_IDLE  = 25'h0000001, ST_ZFILL = 25'h0000002, ST_P_RD  = 25'h0000004,
    ST_P_CHK = 25'h0000008, ST_P_SQ  = 25'h0000010, ST_R_RD  = 25'h0000020,
    ST_R_DIV = 25'h0000040, ST_R_WT  = 25'h0000080, ST_M_RA  = 25'h0000100,
    ST_M_RB  = 25'h0000200, ST_M_MUL = 25'h0000400, ST_M_WR  = 25'h0000800,
    ST_B_RD  = 25'h0001000, ST_B_DG  = 25'h0002000, ST_B_DGW = 25'h0004000,
    ST_B_RA  = 25'h0008000, ST_B_MUL = 25'h0010000, ST_B_ACC = 25'h0020000,
    ST_B_DRD = 25'h0040000, ST_B_DIV = 25'h0080000, ST_B_DVW = 25'h0100000,
    ST_O_RA  = 25'h0200000, ST_O_RB  = 25'h0400000, ST_O_MUL = 25'h0800000,
    ST_O_ACC = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [cspd_pkg::SIZE_W-1:0] size_r;
  logic [LCW-1:0]              load_cnt_r, load_cnt_nxt;
  logic                        piv_err_r, piv_err_nxt;
  logic [CW-1:0]               i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic signed [AccW-1:0]      acc_r, acc_nxt;
  logic signed [VW-1:0]        opa_r, opa_nxt;
  logic signed [VW-1:0]        mk_r, mk_nxt;
  logic signed [63:0]          prod_r, prod_nxt;
  logic [VW-1:0]               d_r, d_nxt;
  logic [5:0]                  step_r, step_nxt;
  // divider
  logic [47:0]                 dmag_r, dmag_nxt;
  logic [32:0]                 drem_r, drem_nxt;
  logic [VW-1:0]               dden_r, dden_nxt;
  logic                        dneg_r, dneg_nxt;
  // square root
  logic [47:0]                 sv_r, sv_nxt;
  logic [26:0]                 srem_r, srem_nxt;
  logic [23:0]                 sroot_r, sroot_nxt;
  // output
  logic                        out_valid_r, out_valid_nxt;
  cspd_pkg::out_item_t         out_data_r, out_data_nxt;

  // memories
  logic           m_we, f_we, u_we;
  logic [AW-1:0]  m_waddr, f_waddr, u_waddr, m_raddr, f_raddr, u_raddr;
  logic [VW-1:0]  m_wdata, f_wdata, u_wdata, m_rdata, f_rdata, u_rdata;

  cspd_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_mstore (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata));
  cspd_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_fstore (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata));
  cspd_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ustore (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata));

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(r[IW-1:0]) * AW'(MAX_SIZE) + AW'(c[IW-1:0]);
  endfunction

  // effective size and element count
  logic [CW-1:0]  n_eff;
  logic [LCW-1:0] total;
  always_comb begin
    if (size_r == '0) begin
      n_eff = CW'(1);
    end else if (int'(size_r) > MAX_SIZE) begin
      n_eff = CW'(MAX_SIZE);
    end else begin
      n_eff = CW'(size_r);
    end
    total = LCW'(n_eff) * LCW'(n_eff);
  end

  // row and column of the load count under the current size
  logic [CW-1:0]  ld_row, ld_col;
  logic [LCW-1:0] ld_base;
  always_comb begin
    ld_row = '0;
    for (int r = 1; r < MAX_SIZE; r++) begin
      if (load_cnt_r >= LCW'(r) * LCW'(n_eff)) ld_row = CW'(r);
    end
    ld_base = LCW'(ld_row) * LCW'(n_eff);
    ld_col  = CW'(load_cnt_r - ld_base);
  end

  // divider iteration and result
  logic [32:0]          d_trial;
  logic                 d_bit;
  logic                 div_done;
  logic signed [VW-1:0] div_q;
  always_comb begin
    d_trial = {drem_r[31:0], dmag_r[47]};
    d_bit   = (d_trial >= {1'b0, dden_r});
    div_done = (step_r == '0);
    if (dneg_r) begin
      if (dmag_r > 48'h0000_8000_0000) div_q = 32'sh8000_0000;
      else div_q = -$signed(dmag_r[VW-1:0]);
    end else begin
      if (dmag_r > 48'h0000_7FFF_FFFF) div_q = 32'sh7FFF_FFFF;
      else div_q = $signed(dmag_r[VW-1:0]);
    end
  end

  // square root iteration
  logic [26:0] s_rem2, s_trial;
  logic        s_bit;
  always_comb begin
    s_rem2  = {srem_r[24:0], sv_r[47:46]};
    s_trial = {1'b0, sroot_r, 2'b01};
    s_bit   = (s_rem2 >= s_trial);
  end

  logic signed [VW-1:0]   q_prod;
  logic signed [AccW-1:0] acc_sum;
  logic signed [VW-1:0]   neg_s;
  logic signed [VW-1:0]   acc_sat;
  always_comb begin
    q_prod  = cspd_pkg::qmul(prod_r);
    acc_sum = acc_r + AccW'(q_prod);
    acc_sat = cspd_pkg::sat64(64'(acc_r));
    neg_s   = cspd_pkg::sat64(-64'(acc_sat));
  end

  logic [CW-1:0] i_inc, j_inc, k_inc;
  assign i_inc = i_r + CW'(1);
  assign j_inc = j_r + CW'(1);
  assign k_inc = k_r + CW'(1);

  logic signed [47:0] div_num;

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    piv_err_nxt   = piv_err_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    mk_nxt   = mk_r;
    prod_nxt = prod_r;
    d_nxt    = d_r;
    step_nxt = step_r;
    dmag_nxt = dmag_r; drem_nxt = drem_r; dden_nxt = dden_r; dneg_nxt = dneg_r;
    sv_nxt = sv_r; srem_nxt = srem_r; sroot_nxt = sroot_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    m_we = 1'b0; f_we = 1'b0; u_we = 1'b0;
    m_waddr = '0; f_waddr = '0; u_waddr = '0;
    m_wdata = '0; f_wdata = '0; u_wdata = '0;
    m_raddr = '0; f_raddr = '0; u_raddr = '0;
    div_num = '0;

    // divider runs whenever its step count is live in a wait state
    if ((state_r == ST_R_WT || state_r == ST_B_DGW || state_r == ST_B_DVW) && !div_done) begin
      drem_nxt = d_bit ? (d_trial - {1'b0, dden_r}) : d_trial;
      dmag_nxt = {dmag_r[46:0], d_bit};
      step_nxt = step_r - 6'd1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (load_cnt_r < total) begin
            m_we    = 1'b1;
            m_waddr = addr_of(ld_row, ld_col);
            m_wdata = in_data.element_value;
            load_cnt_nxt = load_cnt_r + LCW'(1);
          end
          if (in_data.last_element) state_nxt = ST_ZFILL;
        end
      end
      ST_ZFILL: begin
        // pad a short matrix with zeros
        if (load_cnt_r < total) begin
          m_we    = 1'b1;
          m_waddr = addr_of(ld_row, ld_col);
          m_wdata = '0;
          load_cnt_nxt = load_cnt_r + LCW'(1);
        end else begin
          load_cnt_nxt = '0;
          i_nxt = '0;
          state_nxt = ST_P_RD;
        end
      end
      ST_P_RD: begin
        m_raddr   = addr_of(i_r, i_r);
        state_nxt = ST_P_CHK;
      end
      ST_P_CHK: begin
        if ($signed(m_rdata) <= 0) begin
          piv_err_nxt = 1'b1;
          sv_nxt = {32'd1, 16'd0};
        end else begin
          sv_nxt = {m_rdata, 16'd0};
        end
        srem_nxt  = '0;
        sroot_nxt = '0;
        step_nxt  = 6'd24;
        state_nxt = ST_P_SQ;
      end
      ST_P_SQ: begin
        srem_nxt  = s_bit ? (s_rem2 - s_trial) : s_rem2;
        sroot_nxt = {sroot_r[22:0], s_bit};
        sv_nxt    = {sv_r[45:0], 2'b00};
        step_nxt  = step_r - 6'd1;
        if (step_r == 6'd1) begin
          f_we    = 1'b1;
          f_waddr = addr_of(i_r, i_r);
          f_wdata = {8'd0, sroot_r[22:0], s_bit};
          d_nxt   = {8'd0, sroot_r[22:0], s_bit};
          if (i_inc < n_eff) begin
            j_nxt = i_inc;
            state_nxt = ST_R_RD;
          end else begin
            i_nxt = '0;
            state_nxt = ST_B_RD;
          end
        end
      end
      ST_R_RD: begin
        m_raddr   = addr_of(i_r, j_r);
        state_nxt = ST_R_DIV;
      end
      ST_R_DIV: begin
        div_num  = {{16{m_rdata[VW-1]}}, m_rdata} <<< 16;
        dneg_nxt = div_num[47];
        dmag_nxt = div_num[47] ? 48'(-div_num) : 48'(div_num);
        drem_nxt = '0;
        dden_nxt = d_r;
        step_nxt = 6'd48;
        state_nxt = ST_R_WT;
      end
      ST_R_WT: begin
        if (div_done) begin
          f_we    = 1'b1;
          f_waddr = addr_of(i_r, j_r);
          f_wdata = div_q;
          if (j_inc < n_eff) begin
            j_nxt = j_inc;
            state_nxt = ST_R_RD;
          end else begin
            k_nxt = i_inc;
            j_nxt = i_inc;
            state_nxt = ST_M_RA;
          end
        end
      end
      ST_M_RA: begin
        f_raddr   = addr_of(i_r, k_r);
        state_nxt = ST_M_RB;
      end
      ST_M_RB: begin
        opa_nxt   = $signed(f_rdata);
        f_raddr   = addr_of(i_r, j_r);
        m_raddr   = addr_of(k_r, j_r);
        state_nxt = ST_M_MUL;
      end
      ST_M_MUL: begin
        prod_nxt  = 64'(opa_r) * 64'($signed(f_rdata));
        mk_nxt    = $signed(m_rdata);
        state_nxt = ST_M_WR;
      end
      ST_M_WR: begin
        m_we    = 1'b1;
        m_waddr = addr_of(k_r, j_r);
        m_wdata = cspd_pkg::sat64(64'(mk_r) - 64'(q_prod));
        if (j_inc < n_eff) begin
          j_nxt = j_inc;
          state_nxt = ST_M_RA;
        end else if (k_inc < n_eff) begin
          k_nxt = k_inc;
          j_nxt = k_inc;
          state_nxt = ST_M_RA;
        end else begin
          i_nxt = i_inc;
          state_nxt = ST_P_RD;
        end
      end
      ST_B_RD: begin
        f_raddr   = addr_of(i_r, i_r);
        state_nxt = ST_B_DG;
      end
      ST_B_DG: begin
        dneg_nxt = 1'b0;
        dmag_nxt = 48'h0001_0000_0000;
        drem_nxt = '0;
        dden_nxt = f_rdata;
        step_nxt = 6'd48;
        state_nxt = ST_B_DGW;
      end
      ST_B_DGW: begin
        if (div_done) begin
          u_we    = 1'b1;
          u_waddr = addr_of(i_r, i_r);
          u_wdata = div_q;
          if (i_inc < n_eff) begin
            j_nxt = i_inc;
            k_nxt = i_r;
            acc_nxt = '0;
            state_nxt = ST_B_RA;
          end else begin
            i_nxt = '0; j_nxt = '0; k_nxt = '0;
            acc_nxt = '0;
            state_nxt = ST_O_RA;
          end
        end
      end
      ST_B_RA: begin
        u_raddr   = addr_of(i_r, k_r);
        f_raddr   = addr_of(k_r, j_r);
        state_nxt = ST_B_MUL;
      end
      ST_B_MUL: begin
        prod_nxt  = 64'($signed(u_rdata)) * 64'($signed(f_rdata));
        state_nxt = ST_B_ACC;
      end
      ST_B_ACC: begin
        acc_nxt = acc_sum;
        if (k_inc < j_r) begin
          k_nxt = k_inc;
          state_nxt = ST_B_RA;
        end else begin
          state_nxt = ST_B_DRD;
        end
      end
      ST_B_DRD: begin
        f_raddr   = addr_of(j_r, j_r);
        state_nxt = ST_B_DIV;
      end
      ST_B_DIV: begin
        div_num  = {{16{neg_s[VW-1]}}, neg_s} <<< 16;
        dneg_nxt = div_num[47];
        dmag_nxt = div_num[47] ? 48'(-div_num) : 48'(div_num);
        drem_nxt = '0;
        dden_nxt = f_rdata;
        step_nxt = 6'd48;
        state_nxt = ST_B_DVW;
      end
      ST_B_DVW: begin
        if (div_done) begin
          u_we    = 1'b1;
          u_waddr = addr_of(i_r, j_r);
          u_wdata = div_q;
          acc_nxt = '0;
          if (j_inc < n_eff) begin
            j_nxt = j_inc;
            k_nxt = i_r;
            state_nxt = ST_B_RA;
          end else begin
            i_nxt = i_inc;
            state_nxt = ST_B_RD;
          end
        end
      end
      ST_O_RA: begin
        u_raddr   = addr_of(i_r, k_r);
        state_nxt = ST_O_RB;
      end
      ST_O_RB: begin
        opa_nxt   = $signed(u_rdata);
        u_raddr   = addr_of(j_r, k_r);
        state_nxt = ST_O_MUL;
      end
      ST_O_MUL: begin
        prod_nxt  = 64'(opa_r) * 64'($signed(u_rdata));
        state_nxt = ST_O_ACC;
      end
      ST_O_ACC: begin
        if (k_inc < n_eff) begin
          acc_nxt = acc_sum;
          k_nxt = k_inc;
          state_nxt = ST_O_RA;
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt.inverse_value      = cspd_pkg::sat64(64'(acc_sum));
          out_data_nxt.last_result        = (i_inc == n_eff) && (j_inc == n_eff);
          out_data_nxt.pivot_not_positive = piv_err_r;
          acc_nxt = '0;
          if (j_inc < n_eff) begin
            j_nxt = j_inc;
            k_nxt = (i_r > j_inc) ? i_r : j_inc;
            state_nxt = ST_O_RA;
          end else if (i_inc < n_eff) begin
            i_nxt = i_inc;
            j_nxt = '0;
            k_nxt = i_inc;
            state_nxt = ST_O_RA;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= cspd_pkg::SIZE_RESET;
      load_cnt_r  <= '0;
      piv_err_r   <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      piv_err_r   <= piv_err_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      if (cfg_valid && cfg_ready) size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    mk_r   <= mk_nxt;
    prod_r <= prod_nxt;
    d_r    <= d_nxt;
    dmag_r <= dmag_nxt; drem_r <= drem_nxt; dden_r <= dden_nxt; dneg_r <= dneg_nxt;
    sv_r   <= sv_nxt; srem_r <= srem_nxt; sroot_r <= sroot_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "cholesky_spd_inverse_assert.svh"

  `CSPD_ASSERT_NEXT(a_last_starts_run, clk, rst_n, start && !busy && in_data.last_element, busy)
  `CSPD_ASSERT_NEXT(a_flag_sticky, clk, rst_n, piv_err_r, piv_err_r)
  `CSPD_ASSERT_NEXT(a_last_ends_burst, clk, rst_n, out_valid && out_data.last_result, !out_valid)
  `CSPD_ASSERT_IMPLY(a_no_result_while_loading, clk, rst_n, state_r == ST_ZFILL, !out_valid)

endmodule

### verif/tb.sv
// Self-checking testbench for the Cholesky inverse block: predicts A^-1 per matrix.
`timescale 1ns / 100ps

module tb;

  localparam int MAXN = 8;
  localparam int STALL_LIMIT = 20000;
  localparam longint VMAX = 64'sh7FFF_FFFF;
  localparam longint VMIN = -64'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cspd_pkg::in_item_t in_data = '0;
  logic out_valid;
  cspd_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cspd_pkg::SIZE_W-1:0] cfg_data = '0;

  cholesky_spd_inverse dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [cspd_pkg::SIZE_W-1:0] size_reg = cspd_pkg::SIZE_RESET;
  longint a_mat[MAXN*MAXN];
  longint r_fac[MAXN*MAXN];
  longint u_inv[MAXN*MAXN];
  int unsigned loaded = 0;
  bit pivot_bad = 1'b0;
  cspd_pkg::out_item_t expected_inverse[$];
  int errors = 0;
  int items_sent = 0;
  bit no_gaps = 1'b0;

  function automatic longint clip(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clip((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint fx_sqrt(longint p);
    logic [63:0] v, res, b;
    v = 64'(p) << 16;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic int unsigned active_size();
    if (size_reg < 1) return 1;
    if (size_reg > MAXN) return MAXN;
    return size_reg;
  endfunction

  // Factor, invert and queue the n*n expected inverse elements.
  task automatic predict_inverse();
    int unsigned n;
    longint p, d, s;
    cspd_pkg::out_item_t e;
    n = active_size();
    for (int unsigned k = loaded; k < n * n; k++) a_mat[(k / n) * MAXN + k % n] = 0;
    for (int i = 0; i < n; i++) begin
      p = a_mat[i*MAXN+i];
      if (p <= 0) begin
        pivot_bad = 1'b1;
        p = 1;
      end
      d = fx_sqrt(p);
      for (int j = 0; j < i; j++) r_fac[i*MAXN+j] = 0;
      r_fac[i*MAXN+i] = d;
      for (int j = i + 1; j < n; j++) r_fac[i*MAXN+j] = clip((a_mat[i*MAXN+j] * 65536) / d);
      for (int k = i + 1; k < n; k++)
        for (int j = k; j < n; j++)
          a_mat[k*MAXN+j] = clip(a_mat[k*MAXN+j] - fx_mul(r_fac[i*MAXN+k], r_fac[i*MAXN+j]));
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < i; j++) u_inv[i*MAXN+j] = 0;
      u_inv[i*MAXN+i] = clip((64'sd1 <<< 32) / r_fac[i*MAXN+i]);
      for (int j = i + 1; j < n; j++) begin
        s = 0;
        for (int k = i; k < j; k++) s += fx_mul(u_inv[i*MAXN+k], r_fac[k*MAXN+j]);
        s = clip(-clip(s));
        u_inv[i*MAXN+j] = clip((s * 65536) / r_fac[j*MAXN+j]);
      end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        s = 0;
        for (int k = (i > j ? i : j); k < n; k++) s += fx_mul(u_inv[i*MAXN+k], u_inv[j*MAXN+k]);
        e.inverse_value = 32'(clip(s));
        e.last_result = (i * n + j == n * n - 1);
        e.pivot_not_positive = pivot_bad;
        expected_inverse.push_back(e);
      end
    loaded = 0;
  endtask

  // Send one element; start stays high afterwards so back-to-back transfers need no toggle.
  task automatic send_element(logic signed [31:0] value, bit last);
    int gap;
    int unsigned n;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data.element_value <= value;
    in_data.last_element <= last;
    do @(posedge clk); while (busy);
    items_sent++;
    n = active_size();
    if (loaded < n * n) begin
      a_mat[(loaded / n) * MAXN + loaded % n] = value;
      loaded++;
    end
    if (last) predict_inverse();
  endtask

  // Hold off until every expected result has arrived and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_inverse.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [cspd_pkg::SIZE_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = value;
  endtask

  // Test matrix: positive diagonal from 1.0 to 64.0, off-diagonal terms from -1.0 to 1.0.
  task automatic send_spd(int unsigned n);
    for (int unsigned k = 0; k < n * n; k++) begin
      if (k / n == k % n) send_element($urandom_range(32'h1_0000, 32'h40_0000), k == n*n-1);
      else send_element($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000, k == n*n-1);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cspd_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (expected_inverse.size() == 0) begin
        report("unexpected result", out_data.inverse_value, 0);
      end else begin
        e = expected_inverse.pop_front();
        if (out_data.inverse_value !== e.inverse_value)
          report("inverse_value", out_data.inverse_value, e.inverse_value);
        if (out_data.last_result !== e.last_result)
          report("last_result", out_data.last_result, e.last_result);
        if (out_data.pivot_not_positive !== e.pivot_not_positive)
          report("pivot_not_positive", out_data.pivot_not_positive, e.pivot_not_positive);
      end
    end
  end

  // Watchdog on cycles with no transfer of any kind.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_single_element();
    write_size(4'd1);
    send_element(32'sh0001_0000, 1'b1);
    send_element(32'sh7FFF_FFFF, 1'b1);
    send_element(32'sh0000_0001, 1'b1);
    send_element(32'sh0004_0000, 1'b1);
  endtask

  task automatic test_small_matrices();
    write_size(4'd2);
    send_element(32'sh0001_0000, 1'b0);
    send_element(32'sh0000_8000, 1'b0);
    send_element(32'sh7FFF_FFFF, 1'b0);
    send_element(32'sh0002_0000, 1'b1);
    write_size(4'd3);
    send_spd(3);
  endtask

  task automatic test_size_clamp();
    write_size(4'd0);
    send_element(32'sh0009_0000, 1'b1);
    write_size(4'd15);
    no_gaps = 1'b1;
    send_spd(8);
    no_gaps = 1'b0;
  endtask

  task automatic test_marker_cases();
    write_size(4'd2);
    // early marker: rest of the matrix is zero
    send_element(32'sh0004_0000, 1'b0);
    send_element(32'sh0000_4000, 1'b1);
    // surplus elements are dropped
    for (int k = 0; k < 6; k++) send_element(32'sh0002_0000 + k, k == 5);
    // resize mid-load
    send_element(32'sh0003_0000, 1'b0);
    send_element(32'sh0000_1000, 1'b0);
    write_size(4'd3);
    send_element(32'sh0005_0000, 1'b1);
  endtask

  task automatic test_pivot_error();
    write_size(4'd2);
    send_element(32'sh8000_0000, 1'b0);
    send_element(32'sh0001_0000, 1'b0);
    send_element(32'sh0001_0000, 1'b0);
    send_element(32'sh0000_0000, 1'b1);
    send_element(32'sh0001_0000, 1'b1);
  endtask

  task automatic test_random(int upto);
    int unsigned n, cnt;
    while (items_sent < upto) begin
      if ($urandom_range(0, 4) == 0) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        write_size(cspd_pkg::SIZE_W'(n));
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      n = active_size();
      case ($urandom_range(0, 9))
        0: begin
          // noise: full-range values, random marker placement
          cnt = $urandom_range(1, n * n + 3);
          for (int unsigned k = 0; k < cnt; k++) send_element($urandom(), k == cnt - 1);
        end
        1: begin
          cnt = $urandom_range(1, n * n);
          for (int unsigned k = 0; k < cnt; k++)
            send_element($urandom_range(0, 32'h8_0000), k == cnt - 1);
        end
        default: send_spd(n);
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_spd(8);
    test_single_element();
    test_small_matrices();
    test_size_clamp();
    test_marker_cases();
    test_random(270);
    test_pivot_error();
    test_random(390);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_inverse.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
